// ----- src/fpp_pkg.sv -----
// Shared constants for the first-pivot partition block.
package fpp_pkg;

	localparam int PIDX_W = 6;

endpackage

// ----- src/fpp_if.sv -----
// Valid/ready channel interfaces for the element input and the result output.
interface fpp_in_if import fpp_pkg::*; #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value;
	logic                         last_in;

	modport source (output valid, output value, output last_in, input ready);
	modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface fpp_out_if import fpp_pkg::*; #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] result_value;
	logic        [PIDX_W-1:0]     pivot_index;
	logic                         dropped;
	logic                         last_out;

	modport source (output valid, output result_value, output pivot_index,
		output dropped, output last_out, input ready);
	modport sink   (input valid, input result_value, input pivot_index,
		input dropped, input last_out, output ready);
endinterface

// ----- src/first_pivot_partition.sv -----
// Top level: store a set, partition it around its first element, emit it in order.
//
//   channel  dir  payload                                         transfer
//   din      in   value, last_in                                  din.valid & din.ready
//   dout     out  result_value, pivot_index, dropped, last_out    dout.valid & dout.ready
//
// Loading accepts one element per cycle; din is ready only while loading.
// Partitioning steps the single read port of the element memory: each pass of the
// two scans steps both pointers, reads elements while each scan continues, decides,
// then makes two writes for a swap or for placing the pivot.
// Emission reads each element from memory, then offers it on dout until transferred.
// A stalled dout holds the result and the sequencer; din stays low until the
// last element of the set has been transferred. Reset clears all control state.
module first_pivot_partition import fpp_pkg::*; #(
	parameter int MAX_LEN    = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	fpp_in_if.sink       din,
	fpp_out_if.source    dout
);

	localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W  = $clog2(MAX_LEN + 1);
	localparam logic [CNT_W-1:0] LEN_MAX = CNT_W'(MAX_LEN);

	typedef enum logic [3:0] {
		LOAD, I_STEP, I_CHK, J_STEP, J_CHK, DECIDE,
		SWAP_I, SWAP_J, FIN_Z, FIN_J, EMIT, HOLD
	} state_t;

	state_t state_q;

	logic signed [DATA_WIDTH-1:0] mem [MAX_LEN];
	logic signed [DATA_WIDTH-1:0] rd_q;
	logic signed [DATA_WIDTH-1:0] piv_q;
	logic signed [DATA_WIDTH-1:0] vi_q;
	logic signed [DATA_WIDTH-1:0] vj_q;

	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  j_q;
	logic [ADDR_W-1:0] k_q;
	logic              ovf_q;
	logic              ovalid_q;

	logic [CNT_W-1:0]  i_nxt;
	logic [CNT_W-1:0]  j_nxt;
	logic [CNT_W-1:0]  n_load;
	logic              has_room;
	logic              emit_last;

	logic                         rd_en;
	logic [ADDR_W-1:0]            rd_addr;
	logic                         wr_en;
	logic [ADDR_W-1:0]            wr_addr;
	logic signed [DATA_WIDTH-1:0] wr_data;

	assign i_nxt     = i_q + CNT_W'(1);
	assign j_nxt     = j_q - CNT_W'(1);
	assign has_room  = (cnt_q < LEN_MAX);
	assign n_load    = has_room ? cnt_q + CNT_W'(1) : cnt_q;
	assign emit_last = ((CNT_W'(k_q) + CNT_W'(1)) == cnt_q);

	assign din.ready         = (state_q == LOAD);
	assign dout.valid        = ovalid_q;
	assign dout.result_value = rd_q;
	assign dout.pivot_index  = PIDX_W'(j_q);
	assign dout.dropped      = ovf_q;
	assign dout.last_out     = emit_last;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = din.value;
		case (state_q)
			LOAD: begin
				wr_en   = din.valid && has_room;
				wr_addr = cnt_q[ADDR_W-1:0];
			end
			I_STEP: begin
				rd_en   = (i_nxt < cnt_q);
				rd_addr = i_nxt[ADDR_W-1:0];
			end
			I_CHK: begin
				rd_en   = (rd_q <= piv_q) && (i_nxt < cnt_q);
				rd_addr = i_nxt[ADDR_W-1:0];
			end
			J_STEP: begin
				rd_en   = (j_nxt != '0);
				rd_addr = j_nxt[ADDR_W-1:0];
			end
			J_CHK: begin
				rd_en   = (rd_q > piv_q) && (j_nxt != '0);
				rd_addr = j_nxt[ADDR_W-1:0];
			end
			SWAP_I: begin
				wr_en   = 1'b1;
				wr_addr = i_q[ADDR_W-1:0];
				wr_data = vj_q;
			end
			SWAP_J: begin
				wr_en   = 1'b1;
				wr_addr = j_q[ADDR_W-1:0];
				wr_data = vi_q;
			end
			FIN_Z: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = vj_q;
			end
			FIN_J: begin
				wr_en   = 1'b1;
				wr_addr = j_q[ADDR_W-1:0];
				wr_data = piv_q;
			end
			EMIT: begin
				rd_en   = 1'b1;
				rd_addr = k_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// hold pivot and the two swap candidates
	always_ff @(posedge clk) begin
		if (state_q == LOAD && din.valid && cnt_q == '0) begin
			piv_q <= din.value;
		end
		if (state_q == I_CHK && !(rd_q <= piv_q)) begin
			vi_q <= rd_q;
		end
		if (state_q == J_CHK && !(rd_q > piv_q)) begin
			vj_q <= rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= LOAD;
			cnt_q    <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			ovf_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			case (state_q)
				LOAD: begin
					if (din.valid) begin
						cnt_q <= n_load;
						if (!has_room) begin
							ovf_q <= 1'b1;
						end
						if (din.last_in) begin
							i_q     <= '0;
							j_q     <= n_load;
							state_q <= I_STEP;
						end
					end
				end
				I_STEP: begin
					i_q     <= i_nxt;
					state_q <= (i_nxt < cnt_q) ? I_CHK : J_STEP;
				end
				I_CHK: begin
					if (rd_q <= piv_q) begin
						i_q     <= i_nxt;
						state_q <= (i_nxt < cnt_q) ? I_CHK : J_STEP;
					end else begin
						state_q <= J_STEP;
					end
				end
				J_STEP: begin
					j_q     <= j_nxt;
					state_q <= (j_nxt != '0) ? J_CHK : DECIDE;
				end
				J_CHK: begin
					if (rd_q > piv_q) begin
						j_q     <= j_nxt;
						state_q <= (j_nxt != '0) ? J_CHK : DECIDE;
					end else begin
						state_q <= DECIDE;
					end
				end
				DECIDE: begin
					state_q <= (i_q < j_q) ? SWAP_I : FIN_Z;
				end
				SWAP_I: begin
					state_q <= SWAP_J;
				end
				SWAP_J: begin
					state_q <= I_STEP;
				end
				FIN_Z: begin
					state_q <= FIN_J;
				end
				FIN_J: begin
					k_q     <= '0;
					state_q <= EMIT;
				end
				EMIT: begin
					ovalid_q <= 1'b1;
					state_q  <= HOLD;
				end
				HOLD: begin
					if (dout.ready) begin
						ovalid_q <= 1'b0;
						if (emit_last) begin
							cnt_q   <= '0;
							i_q     <= '0;
							j_q     <= '0;
							ovf_q   <= 1'b0;
							state_q <= LOAD;
						end else begin
							k_q     <= k_q + ADDR_W'(1);
							state_q <= EMIT;
						end
					end
				end
				default: begin
					state_q <= LOAD;
				end
			endcase
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Testbench for first_pivot_partition: random and directed sets checked against a partition predictor.
`timescale 1ns / 1ps

module tb_top;
	import fpp_pkg::*;

	localparam int DW          = 32;
	localparam int MAX_LEN     = 64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 40;
	localparam int HOLD_CYCLES = 300;

	localparam logic signed [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};

	typedef enum int {WORDS_FULL, WORDS_NARROW, WORDS_EDGE} word_mix_t;

	typedef struct packed {
		logic signed [DW-1:0] value;
		logic [PIDX_W-1:0]    pidx;
		logic                 dropped;
		logic                 last;
	} part_result_t;

	logic clk = 1'b0;
	logic arst_n;

	fpp_in_if  #(.DATA_WIDTH(DW)) din_ch ();
	fpp_out_if #(.DATA_WIDTH(DW)) dout_ch ();

	first_pivot_partition #(.MAX_LEN(MAX_LEN), .DATA_WIDTH(DW)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch)
	);

	// predictor state
	logic signed [DW-1:0] set_words [MAX_LEN];
	int                   set_len;
	logic                 set_overflow;
	part_result_t         partitioned_q [$];

	logic signed [DW-1:0] outgoing_q [$];
	part_result_t         head_result;
	int                   fail_count = 0;
	int                   cycle_count = 0;
	int                   total_sent;
	int                   sink_gap = 0;
	int                   sink_hold = 0;
	int                   hold_req;
	int                   hold_ack = 0;
	bit                   src_idle_on;
	bit                   snk_idle_on;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				partitioned_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic report_mismatch(input string field, input longint got, input longint want);
		fail_count++;
		$display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
	endtask

	// Store one accepted word; on the closing word, partition the set and queue its results.
	function void load_word(input logic signed [DW-1:0] v, input logic last);
		int i, j, n, k;
		logic signed [DW-1:0] pv, t;
		part_result_t r;
		if (set_len < MAX_LEN) begin
			set_words[set_len] = v;
			set_len++;
		end else begin
			set_overflow = 1'b1;
		end
		if (!last)
			return;
		n = set_len;
		pv = set_words[0];
		i = 0;
		j = n;
		while (i < j) begin
			i++;
			while (i < n && set_words[i] <= pv)
				i++;
			j--;
			while (j > 0 && set_words[j] > pv)
				j--;
			if (i < j) begin
				t = set_words[i];
				set_words[i] = set_words[j];
				set_words[j] = t;
			end
		end
		t = set_words[0];
		set_words[0] = set_words[j];
		set_words[j] = t;
		for (k = 0; k < n; k++) begin
			r.value = set_words[k];
			r.pidx = PIDX_W'(j);
			r.dropped = set_overflow;
			r.last = (k + 1 == n);
			partitioned_q = {partitioned_q, r};
		end
		set_len = 0;
		set_overflow = 1'b0;
	endfunction

	function automatic logic signed [DW-1:0] draw_word(input word_mix_t mix);
		int pick;
		pick = $urandom_range(0, 8);
		case (mix)
			WORDS_NARROW: begin
				return DW'(pick - 4);
			end
			WORDS_EDGE: begin
				case (pick)
					0, 1: return WORD_MIN;
					2, 3: return WORD_MAX;
					4: return '0;
					5: return '1;
					default: return $urandom;
				endcase
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic send_word(input logic signed [DW-1:0] v, input logic last);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 4) : 0;
		repeat (gap) begin
			@(negedge clk);
			din_ch.valid <= 1'b0;
		end
		@(negedge clk);
		din_ch.valid   <= 1'b1;
		din_ch.value   <= v;
		din_ch.last_in <= last;
		do
			@(posedge clk);
		while (!din_ch.ready);
		load_word(v, last);
		total_sent++;
	endtask

	// Transfer every word of outgoing_q; the final one closes the set.
	task automatic send_set();
		logic signed [DW-1:0] v;
		while (outgoing_q.size() != 0) begin
			v = outgoing_q.pop_front();
			send_word(v, outgoing_q.size() == 0);
		end
	endtask

	task automatic test_extremes();
		outgoing_q = '{WORD_MAX};
		send_set();
		outgoing_q = '{WORD_MIN};
		send_set();
		outgoing_q = '{WORD_MIN, WORD_MAX};
		send_set();
		outgoing_q = '{WORD_MAX, WORD_MIN};
		send_set();
		// left scan runs to the end of the set
		outgoing_q = '{WORD_MAX, 5, WORD_MIN, WORD_MAX, -1};
		send_set();
		// right scan stops on words equal to the pivot
		outgoing_q = '{WORD_MIN, 3, WORD_MAX, -7, WORD_MIN};
		send_set();
		outgoing_q = '{0, 0, 0, 0};
		send_set();
		outgoing_q = '{0, 1, -2, 2, -1};
		send_set();
	endtask

	task automatic test_capacity();
		repeat (MAX_LEN)
			outgoing_q = {outgoing_q, draw_word(WORDS_FULL)};
		send_set();
		repeat (MAX_LEN + 6)
			outgoing_q = {outgoing_q, draw_word(WORDS_EDGE)};
		send_set();
		outgoing_q = '{7, 3, 9};
		send_set();
	endtask

	task automatic test_backpressure();
		hold_req++;
		repeat (16)
			outgoing_q = {outgoing_q, draw_word(WORDS_NARROW)};
		send_set();
		repeat (8)
			outgoing_q = {outgoing_q, draw_word(WORDS_FULL)};
		send_set();
	endtask

	task automatic test_random_sets(input int item_goal);
		int len, start;
		word_mix_t mix;
		start = total_sent;
		while (total_sent - start < item_goal) begin
			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(33, MAX_LEN)
				: $urandom_range(1, 12);
			mix = word_mix_t'($urandom_range(0, 2));
			repeat (len)
				outgoing_q = {outgoing_q, draw_word(mix)};
			send_set();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && dout_ch.valid && dout_ch.ready) begin
			if (partitioned_q.size() == 0) begin
				report_mismatch("result with nothing expected",
					longint'(dout_ch.result_value), longint'(0));
			end else begin
				head_result = partitioned_q.pop_front();
				if (dout_ch.result_value !== head_result.value)
					report_mismatch("result_value", longint'(dout_ch.result_value),
						longint'(head_result.value));
				if (dout_ch.pivot_index !== head_result.pidx)
					report_mismatch("pivot_index", longint'(dout_ch.pivot_index),
						longint'(head_result.pidx));
				if (dout_ch.dropped !== head_result.dropped)
					report_mismatch("dropped", longint'(dout_ch.dropped),
						longint'(head_result.dropped));
				if (dout_ch.last_out !== head_result.last)
					report_mismatch("last_out", longint'(dout_ch.last_out),
						longint'(head_result.last));
			end
		end
	end

	initial begin
		dout_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dout_ch.valid && dout_ch.ready)
				sink_gap = snk_idle_on ? $urandom_range(0, 4) : 0;
			@(negedge clk);
			if (hold_req != hold_ack) begin
				sink_hold = HOLD_CYCLES;
				hold_ack  = hold_req;
			end
			if (sink_hold > 0) begin
				dout_ch.ready <= 1'b0;
				sink_hold--;
			end else if (sink_gap > 0) begin
				dout_ch.ready <= 1'b0;
				sink_gap--;
			end else begin
				dout_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n         = 1'b0;
		din_ch.valid   = 1'b0;
		din_ch.value   = '0;
		din_ch.last_in = 1'b0;
		set_len        = 0;
		set_overflow   = 1'b0;
		total_sent     = 0;
		hold_req       = 0;
		src_idle_on    = 1'b1;
		snk_idle_on    = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes();
		test_capacity();
		test_backpressure();
		test_random_sets(70);

		@(negedge clk);
		din_ch.valid <= 1'b0;
		while (partitioned_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/fpp_pkg.sv
src/fpp_if.sv
src/first_pivot_partition.sv
tb/tb_top.sv
